// File: hw/rtl/convex_hull_monotone_chain_assert.svh
// Assertion macros used by the checker of the convex hull block.
`ifndef CONVEX_HULL_MONOTONE_CHAIN_ASSERT_SVH
`define CONVEX_HULL_MONOTONE_CHAIN_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/chm_pkg.sv
// ----------------------------------------------------------------------------
// Convex hull package
// Shared types and constants of the monotone chain convex hull block.
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int unsigned FIELD_W = 16;

  typedef struct packed {
    logic store;
    logic last;
  } chm_ctl_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_SORT_KEY,
    ST_SORT_KEYW,
    ST_SORT_CMP,
    ST_SORT_PUT,
    ST_DEDUP_RD,
    ST_DEDUP_CHK,
    ST_HULL_RD,
    ST_HULL_PT,
    ST_HULL_CHK,
    ST_HULL_MUL,
    ST_HULL_DEC,
    ST_HULL_REFILL,
    ST_HULL_PUSH,
    ST_OUT_RD,
    ST_OUT_EMIT
  } chm_state_e;

endpackage

// File: hw/rtl/chm_if.sv
// ----------------------------------------------------------------------------
// Convex hull channels
// Point input channel and hull vertex output channel.
// ----------------------------------------------------------------------------
interface chm_in_if;
  import chm_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] px;
  logic [FIELD_W-1:0] py;
  logic               set_end;
  modport source (output valid, px, py, set_end, input ready);
  modport sink   (input valid, px, py, set_end, output ready);
endinterface

interface chm_out_if;
  import chm_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] hx;
  logic [FIELD_W-1:0] hy;
  logic               hull_end;
  logic               overflowed;
  modport source (output valid, hx, hy, hull_end, overflowed, input ready);
  modport sink   (input valid, hx, hy, hull_end, overflowed, output ready);
endinterface

// File: hw/rtl/chm_front.sv
// ----------------------------------------------------------------------------
// Convex hull front end
// Accepts points, narrows coordinates and marks each as stored or dropped.
// ----------------------------------------------------------------------------
module chm_front #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  chm_in_if.sink                pt_i,
  output logic                  q_valid_o,
  input  logic                  q_ready_i,
  output chm_pkg::chm_ctl_t     q_ctl_o,
  output logic [COORD_BITS-1:0] q_x_o,
  output logic [COORD_BITS-1:0] q_y_o
);
  import chm_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [FIELD_W+COORD_BITS-1:0] xw, yw;
  logic full, acc;

  // Inputs are read as unsigned fields, only the low COORD_BITS bits count.
  assign xw = {{COORD_BITS{1'b0}}, pt_i.px};
  assign yw = {{COORD_BITS{1'b0}}, pt_i.py};
  assign q_x_o = xw[COORD_BITS-1:0];
  assign q_y_o = yw[COORD_BITS-1:0];

  assign full          = (cnt_q == CNT_W'(MAX_POINTS));
  assign q_ctl_o.store = !full;
  assign q_ctl_o.last  = pt_i.set_end;
  assign q_valid_o     = pt_i.valid;
  assign pt_i.ready    = q_ready_i;
  assign acc           = pt_i.valid && q_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (acc) begin
      if (pt_i.set_end) begin
        cnt_d = '0;
      end else if (!full) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: hw/rtl/chm_fifo.sv
// ----------------------------------------------------------------------------
// Convex hull queue
// Two-entry queue between the front end and the hull engine.
// ----------------------------------------------------------------------------
module chm_fifo #(
  parameter int unsigned WIDTH = 34
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  logic [WIDTH-1:0] data_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = data_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      data_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= !wptr_q;
      end
      if (pop) begin
        rptr_q <= !rptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// File: hw/rtl/chm_back.sv
// ----------------------------------------------------------------------------
// Convex hull engine
// Stores a point set, sorts it, removes duplicates, builds both chains and
// streams the hull vertices out.
// ----------------------------------------------------------------------------
module chm_back #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  output logic                  q_ready_o,
  input  chm_pkg::chm_ctl_t     q_ctl_i,
  input  logic [COORD_BITS-1:0] q_x_i,
  input  logic [COORD_BITS-1:0] q_y_i,
  chm_out_if.source             hull_o
);
  import chm_pkg::*;

  localparam int unsigned CW    = COORD_BITS;
  localparam int unsigned PW    = 2 * CW;
  localparam int unsigned AW    = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned MW    = 2 * CW + 2;
  localparam int unsigned XW    = 2 * CW + 3;

  function automatic logic [FIELD_W-1:0] to_field(input logic [CW-1:0] v);
    logic [FIELD_W+CW-1:0] s;
    s = {{FIELD_W{v[CW-1]}}, v};
    return s[FIELD_W-1:0];
  endfunction

  function automatic logic pt_less(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic signed [CW-1:0] ax, ay, bx, by;
    ax = a[PW-1:CW];
    ay = a[CW-1:0];
    bx = b[PW-1:CW];
    by = b[CW-1:0];
    return (ax < bx) || ((ax == bx) && (ay < by));
  endfunction

  // Storage
  logic [PW-1:0] pmem [MAX_POINTS];
  logic [PW-1:0] umem [MAX_POINTS];
  logic [PW-1:0] lmem [MAX_POINTS];
  logic [PW-1:0] p_rd_q, u_rd_q, l_rd_q;

  logic             p_we, p_re, u_we, l_we, u_re, l_re;
  logic [CNT_W-1:0] p_widx, p_ridx, s_widx, s_ridx;
  logic [PW-1:0]    p_wdata;

  chm_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d, m_q, m_d;
  logic [CNT_W-1:0] ut_q, ut_d, lt_q, lt_d, k_q, k_d;
  logic drop_q, drop_d, side_q, side_d, ph_q, ph_d;
  logic [PW-1:0] key_q, key_d, last_q, last_d, p_q, p_d;
  logic [PW-1:0] u1_q, u1_d, u2_q, u2_d, l1_q, l1_d, l2_q, l2_d;

  logic ov_q, ov_d, oend_q, oend_d, oovf_q, oovf_d;
  logic [FIELD_W-1:0] ox_q, ox_d, oy_q, oy_d;

  // Cross product datapath, free running: differences and products are registered.
  logic [CNT_W-1:0] top_sel;
  logic [PW-1:0]    t1_sel, t2_sel, s_rd_sel, o_pt;
  logic signed [CW:0] dax, day, dqx, dqy;
  logic signed [CW:0] dax_q, day_q, dqx_q, dqy_q;
  logic signed [MW-1:0] pr1_q, pr2_q;
  logic signed [XW-1:0] xprod;
  logic pop_pt, out_free;

  assign top_sel  = side_q ? lt_q : ut_q;
  assign t1_sel   = side_q ? l1_q : u1_q;
  assign t2_sel   = side_q ? l2_q : u2_q;
  assign s_rd_sel = side_q ? l_rd_q : u_rd_q;

  assign dax = $signed({t2_sel[PW-1], t2_sel[PW-1:CW]}) - $signed({t1_sel[PW-1], t1_sel[PW-1:CW]});
  assign day = $signed({t2_sel[CW-1], t2_sel[CW-1:0]}) - $signed({t1_sel[CW-1], t1_sel[CW-1:0]});
  assign dqx = $signed({p_q[PW-1], p_q[PW-1:CW]}) - $signed({t1_sel[PW-1], t1_sel[PW-1:CW]});
  assign dqy = $signed({p_q[CW-1], p_q[CW-1:0]}) - $signed({t1_sel[CW-1], t1_sel[CW-1:0]});

  always_ff @(posedge clk_i) begin
    dax_q <= dax;
    day_q <= day;
    dqx_q <= dqx;
    dqy_q <= dqy;
    pr1_q <= MW'(dax_q * dqy_q);
    pr2_q <= MW'(day_q * dqx_q);
  end

  assign xprod = $signed({pr1_q[MW-1], pr1_q}) - $signed({pr2_q[MW-1], pr2_q});
  // The upper chain drops its top on a non-right turn, the lower one on a
  // non-left turn, so collinear points never stay on either chain.
  assign pop_pt = side_q ? !xprod[XW-1] : (xprod[XW-1] || (xprod == '0));

  assign out_free = !ov_q || hull_o.ready;
  assign o_pt     = ph_q ? u_rd_q : l_rd_q;

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      pmem[p_widx[AW-1:0]] <= p_wdata;
    end
    if (p_re) begin
      p_rd_q <= pmem[p_ridx[AW-1:0]];
    end
    if (u_we) begin
      umem[s_widx[AW-1:0]] <= p_q;
    end
    if (u_re) begin
      u_rd_q <= umem[s_ridx[AW-1:0]];
    end
    if (l_we) begin
      lmem[s_widx[AW-1:0]] <= p_q;
    end
    if (l_re) begin
      l_rd_q <= lmem[s_ridx[AW-1:0]];
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;  i_d = i_q;   j_d = j_q;   m_d = m_q;
    ut_d = ut_q;    lt_d = lt_q; k_d = k_q;
    drop_d = drop_q; side_d = side_q; ph_d = ph_q;
    key_d = key_q;  last_d = last_q; p_d = p_q;
    u1_d = u1_q; u2_d = u2_q; l1_d = l1_q; l2_d = l2_q;
    ov_d = ov_q;  oend_d = oend_q; oovf_d = oovf_q; ox_d = ox_q; oy_d = oy_q;
    p_we = 1'b0; p_re = 1'b0; u_we = 1'b0; l_we = 1'b0; u_re = 1'b0; l_re = 1'b0;
    p_widx = '0; p_ridx = '0; s_widx = '0; s_ridx = '0; p_wdata = key_q;
    q_ready_o = 1'b0;

    if (ov_q && hull_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      ST_LOAD: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          if (q_ctl_i.store) begin
            p_we    = 1'b1;
            p_widx  = cnt_q;
            p_wdata = {q_x_i, q_y_i};
            cnt_d   = cnt_q + CNT_W'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (q_ctl_i.last) begin
            i_d = CNT_W'(1);
            m_d = '0;
            if (cnt_d > CNT_W'(1)) begin
              state_d = ST_SORT_KEY;
            end else begin
              i_d     = '0;
              state_d = ST_DEDUP_RD;
            end
          end
        end
      end
      ST_SORT_KEY: begin
        p_re    = 1'b1;
        p_ridx  = i_q;
        state_d = ST_SORT_KEYW;
      end
      ST_SORT_KEYW: begin
        key_d   = p_rd_q;
        j_d     = i_q;
        p_re    = 1'b1;
        p_ridx  = i_q - CNT_W'(1);
        state_d = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        p_we   = 1'b1;
        p_widx = j_q;
        if (pt_less(key_q, p_rd_q)) begin
          p_wdata = p_rd_q;
          j_d     = j_q - CNT_W'(1);
          if (j_q != CNT_W'(1)) begin
            p_re   = 1'b1;
            p_ridx = j_q - CNT_W'(2);
          end else begin
            state_d = ST_SORT_PUT;
          end
        end else begin
          i_d = i_q + CNT_W'(1);
          if (i_d < cnt_q) begin
            state_d = ST_SORT_KEY;
          end else begin
            i_d     = '0;
            state_d = ST_DEDUP_RD;
          end
        end
      end
      ST_SORT_PUT: begin
        p_we   = 1'b1;
        p_widx = j_q;
        i_d    = i_q + CNT_W'(1);
        if (i_d < cnt_q) begin
          state_d = ST_SORT_KEY;
        end else begin
          i_d     = '0;
          state_d = ST_DEDUP_RD;
        end
      end
      ST_DEDUP_RD: begin
        p_re    = 1'b1;
        p_ridx  = i_q;
        state_d = ST_DEDUP_CHK;
      end
      ST_DEDUP_CHK: begin
        if ((m_q == '0) || (p_rd_q != last_q)) begin
          p_we    = 1'b1;
          p_widx  = m_q;
          p_wdata = p_rd_q;
          last_d  = p_rd_q;
          m_d     = m_q + CNT_W'(1);
        end
        i_d = i_q + CNT_W'(1);
        if (i_d < cnt_q) begin
          state_d = ST_DEDUP_RD;
        end else begin
          i_d     = '0;
          ut_d    = '0;
          lt_d    = '0;
          state_d = ST_HULL_RD;
        end
      end
      ST_HULL_RD: begin
        p_re    = 1'b1;
        p_ridx  = i_q;
        state_d = ST_HULL_PT;
      end
      ST_HULL_PT: begin
        p_d     = p_rd_q;
        side_d  = 1'b0;
        state_d = ST_HULL_CHK;
      end
      ST_HULL_CHK: begin
        state_d = (top_sel >= CNT_W'(2)) ? ST_HULL_MUL : ST_HULL_PUSH;
      end
      ST_HULL_MUL: begin
        state_d = ST_HULL_DEC;
      end
      ST_HULL_DEC: begin
        if (pop_pt) begin
          if (side_q) begin
            lt_d = lt_q - CNT_W'(1);
            l1_d = l2_q;
          end else begin
            ut_d = ut_q - CNT_W'(1);
            u1_d = u2_q;
          end
          if (top_sel >= CNT_W'(3)) begin
            s_ridx  = top_sel - CNT_W'(3);
            l_re    = side_q;
            u_re    = !side_q;
            state_d = ST_HULL_REFILL;
          end else begin
            state_d = ST_HULL_CHK;
          end
        end else begin
          state_d = ST_HULL_PUSH;
        end
      end
      ST_HULL_REFILL: begin
        if (side_q) begin
          l2_d = s_rd_sel;
        end else begin
          u2_d = s_rd_sel;
        end
        state_d = ST_HULL_CHK;
      end
      ST_HULL_PUSH: begin
        s_widx = top_sel;
        if (side_q) begin
          l_we = 1'b1;
          l2_d = l1_q;
          l1_d = p_q;
          lt_d = lt_q + CNT_W'(1);
          i_d  = i_q + CNT_W'(1);
          if (i_d < m_q) begin
            state_d = ST_HULL_RD;
          end else begin
            k_d     = '0;
            ph_d    = 1'b0;
            state_d = ST_OUT_RD;
          end
        end else begin
          u_we    = 1'b1;
          u2_d    = u1_q;
          u1_d    = p_q;
          ut_d    = ut_q + CNT_W'(1);
          side_d  = 1'b1;
          state_d = ST_HULL_CHK;
        end
      end
      ST_OUT_RD: begin
        s_ridx  = k_q;
        l_re    = !ph_q;
        u_re    = ph_q;
        state_d = ST_OUT_EMIT;
      end
      ST_OUT_EMIT: begin
        if (out_free) begin
          ov_d   = 1'b1;
          ox_d   = to_field(o_pt[PW-1:CW]);
          oy_d   = to_field(o_pt[CW-1:0]);
          oovf_d = drop_q;
          oend_d = ph_q ? (k_q == CNT_W'(1)) : (lt_q == CNT_W'(1));
          state_d = ST_OUT_RD;
          if (oend_d) begin
            cnt_d   = '0;
            drop_d  = 1'b0;
            ut_d    = '0;
            lt_d    = '0;
            state_d = ST_LOAD;
          end else if (!ph_q && (k_q + CNT_W'(2) < lt_q)) begin
            k_d = k_q + CNT_W'(1);
          end else if (!ph_q) begin
            ph_d = 1'b1;
            k_d  = ut_q - CNT_W'(1);
          end else begin
            k_d = k_q - CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      m_q     <= '0;
      ut_q    <= '0;
      lt_q    <= '0;
      k_q     <= '0;
      drop_q  <= 1'b0;
      side_q  <= 1'b0;
      ph_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      j_q     <= j_d;
      m_q     <= m_d;
      ut_q    <= ut_d;
      lt_q    <= lt_d;
      k_q     <= k_d;
      drop_q  <= drop_d;
      side_q  <= side_d;
      ph_q    <= ph_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    last_q <= last_d;
    p_q    <= p_d;
    u1_q   <= u1_d;
    u2_q   <= u2_d;
    l1_q   <= l1_d;
    l2_q   <= l2_d;
    ox_q   <= ox_d;
    oy_q   <= oy_d;
    oend_q <= oend_d;
    oovf_q <= oovf_d;
  end

  assign hull_o.valid      = ov_q;
  assign hull_o.hx         = ox_q;
  assign hull_o.hy         = oy_q;
  assign hull_o.hull_end   = oend_q;
  assign hull_o.overflowed = oovf_q;

endmodule

// File: hw/rtl/convex_hull_monotone_chain.sv
// ----------------------------------------------------------------------------
// Convex hull, monotone chain
// Loads a point set, then emits its hull vertices counterclockwise.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                            | transfer when
//  pt_i     | in  | px, py, set_end                    | valid && ready
//  hull_o   | out | hx, hy, hull_end, overflowed       | valid && ready
//
// Points load at one per cycle, while the engine is in its load state,
// through a two-entry queue into the engine. After the closing point the
// engine runs insertion sort, a duplicate scan, then builds both chains
// with cross product turn tests, and emits the hull vertices in turn.
// Input stalls during that time once the queue is full. Reset empties the
// set; no clearing pass is needed.
module convex_hull_monotone_chain #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  chm_in_if.sink    pt_i,
  chm_out_if.source hull_o
);
  import chm_pkg::*;

  localparam int unsigned QW = $bits(chm_ctl_t) + 2 * COORD_BITS;

  logic                  f_valid, f_ready, b_valid, b_ready;
  chm_ctl_t              f_ctl, b_ctl;
  logic [COORD_BITS-1:0] f_x, f_y, b_x, b_y;

  chm_front #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pt_i      (pt_i),
    .q_valid_o (f_valid),
    .q_ready_i (f_ready),
    .q_ctl_o   (f_ctl),
    .q_x_o     (f_x),
    .q_y_o     (f_y)
  );

  chm_fifo #(.WIDTH(QW)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  ({f_ctl, f_x, f_y}),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   ({b_ctl, b_x, b_y})
  );

  chm_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (b_valid),
    .q_ready_o (b_ready),
    .q_ctl_i   (b_ctl),
    .q_x_i     (b_x),
    .q_y_i     (b_y),
    .hull_o    (hull_o)
  );

endmodule

// File: hw/rtl/chm_checker.sv
// ----------------------------------------------------------------------------
// Convex hull checker
// Port-level checks on the hull vertex stream.
// ----------------------------------------------------------------------------
`include "convex_hull_monotone_chain_assert.svh"

module chm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic [15:0] hx_i,
  input logic [15:0] hy_i,
  input logic        hull_end_i,
  input logic        overflowed_i
);
  logic        mid_q, ovf_q;
  logic [15:0] px_q, py_q;

  // Tracks the previous vertex of the hull that is being streamed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= 1'b0;
      ovf_q <= 1'b0;
      px_q  <= '0;
      py_q  <= '0;
    end else if (valid_i && ready_i) begin
      mid_q <= !hull_end_i;
      ovf_q <= overflowed_i;
      px_q  <= hx_i;
      py_q  <= hy_i;
    end
  end

  `CHM_ASSERT_NXT(a_valid_hold, clk_i, rst_ni, valid_i && !ready_i, valid_i, "vertex withdrawn")
  `CHM_ASSERT_NXT(a_data_hold, clk_i, rst_ni, valid_i && !ready_i, $stable({hx_i, hy_i, hull_end_i}), "vertex changed while stalled")
  `CHM_ASSERT_IMP(a_ovf_same, clk_i, rst_ni, valid_i && mid_q, overflowed_i == ovf_q, "overflow flag changed within a hull")
  `CHM_ASSERT_IMP(a_vert_new, clk_i, rst_ni, valid_i && mid_q, (hx_i != px_q) || (hy_i != py_q), "vertex repeated")

endmodule

bind convex_hull_monotone_chain chm_checker u_chm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .valid_i      (hull_o.valid),
  .ready_i      (hull_o.ready),
  .hx_i         (hull_o.hx),
  .hy_i         (hull_o.hy),
  .hull_end_i   (hull_o.hull_end),
  .overflowed_i (hull_o.overflowed)
);

// File: sim/tb_convex_hull_monotone_chain.sv
// ----------------------------------------------------------------------------
// Convex hull testbench
// Sends point sets and checks every hull vertex against a monotone chain
// predictor, with random gaps on the point side and stalls on the hull side.
// ----------------------------------------------------------------------------
module tb_convex_hull_monotone_chain;
  timeunit 1ns;
  timeprecision 1ps;
  import chm_pkg::*;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [FIELD_W-1:0] hx;
    logic [FIELD_W-1:0] hy;
    logic               hull_end;
    logic               overflowed;
  } vertex_t;

  class hull_scoreboard;
    shortint set_x[$];
    shortint set_y[$];
    bit      dropped;
    vertex_t vertices_due[$];
    int      errors;

    function longint turn(int a, int b, int p);
      longint ax, ay, qx, qy;
      ax = longint'(set_x[a]) - set_x[b];
      ay = longint'(set_y[a]) - set_y[b];
      qx = longint'(set_x[p]) - set_x[b];
      qy = longint'(set_y[p]) - set_y[b];
      return ax * qy - ay * qx;
    endfunction

    function void push_vertex(int idx, bit last);
      vertex_t v;
      v.hx = set_x[idx];
      v.hy = set_y[idx];
      v.hull_end = last;
      v.overflowed = dropped;
      vertices_due.push_back(v);
    endfunction

    // Sorts, removes duplicates and builds both chains of the closed set.
    function void close_set();
      shortint kx, ky;
      int j, m;
      int lower[$];
      int upper[$];
      for (int i = 1; i < set_x.size(); i++) begin
        kx = set_x[i];
        ky = set_y[i];
        j = i;
        while (j > 0 && (kx < set_x[j-1] || (kx == set_x[j-1] && ky < set_y[j-1]))) begin
          set_x[j] = set_x[j-1];
          set_y[j] = set_y[j-1];
          j--;
        end
        set_x[j] = kx;
        set_y[j] = ky;
      end
      m = 0;
      for (int i = 0; i < set_x.size(); i++) begin
        if (m == 0 || set_x[i] != set_x[m-1] || set_y[i] != set_y[m-1]) begin
          set_x[m] = set_x[i];
          set_y[m] = set_y[i];
          m++;
        end
      end
      if (m == 1) begin
        push_vertex(0, 1'b1);
      end else if (m >= 2) begin
        for (int i = 0; i < m; i++) begin
          while (upper.size() >= 2 &&
                 turn(upper[upper.size()-2], upper[upper.size()-1], i) <= 0)
            upper.delete(upper.size() - 1);
          upper.push_back(i);
          while (lower.size() >= 2 &&
                 turn(lower[lower.size()-2], lower[lower.size()-1], i) >= 0)
            lower.delete(lower.size() - 1);
          lower.push_back(i);
        end
        for (int i = 0; i + 1 < lower.size(); i++) push_vertex(lower[i], 1'b0);
        for (int i = upper.size() - 1; i >= 1; i--) push_vertex(upper[i], i == 1);
      end
      set_x.delete();
      set_y.delete();
      dropped = 1'b0;
    endfunction

    function void note_point(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y, logic last);
      if (set_x.size() < CAPACITY) begin
        set_x.push_back(shortint'(x));
        set_y.push_back(shortint'(y));
      end else begin
        dropped = 1'b1;
      end
      if (last) close_set();
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t want;
      if (vertices_due.size() == 0) begin
        $error("unexpected hull vertex x=%0d y=%0d", $signed(got.hx), $signed(got.hy));
        errors++;
        return;
      end
      want = vertices_due.pop_front();
      if (got.hx !== want.hx) begin
        $error("hx: expected %0d, actual %0d", $signed(want.hx), $signed(got.hx));
        errors++;
      end
      if (got.hy !== want.hy) begin
        $error("hy: expected %0d, actual %0d", $signed(want.hy), $signed(got.hy));
        errors++;
      end
      if (got.hull_end !== want.hull_end) begin
        $error("hull_end: expected %0b, actual %0b", want.hull_end, got.hull_end);
        errors++;
      end
      if (got.overflowed !== want.overflowed) begin
        $error("overflowed: expected %0b, actual %0b", want.overflowed, got.overflowed);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  chm_in_if  pt_if();
  chm_out_if hull_if();

  convex_hull_monotone_chain uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pt_i  (pt_if.sink),
    .hull_o(hull_if.source)
  );

  hull_scoreboard sb = new();
  bit  no_idle;
  int  cycles;
  int  n_sent;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    vertex_t got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    if (rst_ni && pt_if.valid && pt_if.ready)
      sb.note_point(pt_if.px, pt_if.py, pt_if.set_end);
    if (rst_ni && hull_if.valid && hull_if.ready) begin
      got.hx = hull_if.hx;
      got.hy = hull_if.hy;
      got.hull_end = hull_if.hull_end;
      got.overflowed = hull_if.overflowed;
      sb.check_vertex(got);
    end
  end

  // Hull side: random stalls between transfers.
  initial begin
    int stall;
    hull_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 10);
      repeat (stall) begin
        @(negedge clk_i);
        hull_if.ready = 1'b0;
      end
      @(negedge clk_i);
      hull_if.ready = 1'b1;
      do @(posedge clk_i); while (!hull_if.valid);
    end
  end

  task automatic send_point(shortint x, shortint y, bit last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk_i);
      pt_if.valid = 1'b0;
    end
    @(negedge clk_i);
    pt_if.valid = 1'b1;
    pt_if.px = x;
    pt_if.py = y;
    pt_if.set_end = last;
    do @(posedge clk_i); while (!pt_if.ready);
    n_sent++;
  endtask

  function automatic shortint rand_coord(int mode);
    case (mode)
      0: return shortint'($urandom_range(0, 6)) - 3;
      1: return ($urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
      default: return shortint'($urandom());
    endcase
  endfunction

  task automatic send_random_set(int size);
    int mode;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < size; i++)
      send_point(rand_coord(mode), rand_coord(mode), i == size - 1);
  endtask

  initial begin
    pt_if.valid = 1'b0;
    pt_if.px = '0;
    pt_if.py = '0;
    pt_if.set_end = 1'b0;
    no_idle = 1'b0;
    n_sent = 0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // One point, then a set of one point given twice.
    send_point(16'sh7FFF, 16'sh8000, 1'b1);
    send_point(5, 5, 1'b0);
    send_point(5, 5, 1'b1);
    // Two distinct points at the extremes, given larger first.
    send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_point(16'sh8000, 16'sh8000, 1'b1);
    // Collinear points keep only the two ends.
    send_point(2, 2, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(1, 1, 1'b0);
    send_point(3, 3, 1'b1);
    // Square with interior and edge points.
    send_point(-4, -4, 1'b0);
    send_point(4, -4, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(4, 4, 1'b0);
    send_point(0, 4, 1'b0);
    send_point(-4, 4, 1'b1);
    // Extreme corners.
    send_point(16'sh8000, 16'sh7FFF, 1'b0);
    send_point(16'sh7FFF, 16'sh8000, 1'b0);
    send_point(16'sh8000, 16'sh8000, 1'b0);
    send_point(16'sh7FFF, 16'sh7FFF, 1'b1);
    // A full store plus extra points, the closing one dropped too.
    for (int i = 0; i < 67; i++)
      send_point(rand_coord(2), rand_coord(2), i == 66);

    while (n_sent < 200) begin
      int size;
      no_idle = ($urandom_range(0, 3) == 0);
      size = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
      send_random_set(size);
    end
    @(negedge clk_i);
    pt_if.valid = 1'b0;

    while (sb.vertices_due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
